@@ sv/hws_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package hws_pkg;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int INV_GAIN_Q16 = 39797;
   localparam int QDEPTH = 2;

   localparam logic [14:0] HARD_RST = 15'd16384;
   localparam logic [14:0] SOFT_RST = 15'd12743;
   localparam logic [14:0] NOT_RST = 15'd1820;
   localparam logic [14:0] MAXS_RST = 15'd2560;

   localparam logic [1:0] REG_HARD = 2'd0;
   localparam logic [1:0] REG_SOFT = 2'd1;
   localparam logic [1:0] REG_NOT = 2'd2;
   localparam logic [1:0] REG_MAXS = 2'd3;

   typedef enum logic [1:0] {MODE_NO = 2'd0, MODE_SOFT = 2'd1, MODE_HARD = 2'd2} mode_type;

   typedef enum logic [2:0] {S_IDLE, S_ITER, S_GAIN, S_MODE, S_DIV, S_OUT} back_state_type;

   typedef struct packed {
      logic        zero;
      logic signed [25:0] x;
      logic signed [25:0] y;
      logic signed [33:0] z;
   } job_type;

   typedef struct packed {
      logic [14:0] hard;
      logic [14:0] softt;
      logic [14:0] nott;
      logic [14:0] maxs;
   } cfg_type;

   function automatic logic [31:0] atan_lookup(input logic [4:0] i);
      logic [31:0] r;
      begin
         case (i)
            5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E; 5'd2: r = 32'h09FB385B;
            5'd3: r = 32'h051111D4; 5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
            5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55; 5'd8: r = 32'h0028BE53;
            5'd9: r = 32'h00145F2F; 5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
            default: r = 32'h0;
         endcase
         return r;
      end
   endfunction
endpackage
`default_nettype wire

@@ sv/heading_to_wheel_speeds.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Heading vector to differential wheel speeds.
// Request channel: req_push/req_full with req_heading_x/y (signed Q8.8).
// A request is taken when push is high and full is low; a two-entry queue
// holds requests pre-rotated into the right half plane.
// Result channel: rsp_empty/rsp_pop with left/right speed and turn mode;
// the result is valid while empty is low and leaves on pop.
// Steps: the job is taken out of the queue, then CORDIC_STEPS iterations (at
// most ATAN_ENTRIES, one per cycle), gain, mode update and output, with a serial
// divide before the output in soft turn. One request is worked on at a time:
// the next one is taken from the queue only after the last has gone to output.
// A finished result waits in the output register; while it is not popped
// the next request finishes computing and waits, the queue keeps filling.
// Reset: thresholds and max speed take their defaults, mode is no turn,
// queue and result register are empty.
// CSR: APB writes at byte address 4*i, reads return the register.
module heading_to_wheel_speeds #(
   parameter int CORDIC_STEPS = hws_pkg::CORDIC_STEPS_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_push,
   output logic               req_full,
   input  wire signed [15:0]  req_heading_x,
   input  wire signed [15:0]  req_heading_y,
   output logic               rsp_empty,
   input  wire                rsp_pop,
   output logic signed [16:0] rsp_left_speed,
   output logic signed [16:0] rsp_right_speed,
   output logic [1:0]         rsp_turn_mode,
   input  wire                csr_psel,
   input  wire                csr_penable,
   input  wire                csr_pwrite,
   input  wire [3:0]          csr_paddr,
   input  wire [31:0]         csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   hws_pkg::cfg_type cfg_ff, cfg_in;
   hws_pkg::job_type job;
   logic job_valid, job_take, wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr && csr_paddr[1:0] == 2'b00) begin
         case (csr_paddr[3:2])
            hws_pkg::REG_HARD: cfg_in.hard = csr_pwdata[14:0];
            hws_pkg::REG_SOFT: cfg_in.softt = csr_pwdata[14:0];
            hws_pkg::REG_NOT:  cfg_in.nott = csr_pwdata[14:0];
            hws_pkg::REG_MAXS: cfg_in.maxs = csr_pwdata[14:0];
            default: ;
         endcase
      end
      case (csr_paddr[3:2])
         hws_pkg::REG_HARD: csr_prdata = {17'd0, cfg_ff.hard};
         hws_pkg::REG_SOFT: csr_prdata = {17'd0, cfg_ff.softt};
         hws_pkg::REG_NOT:  csr_prdata = {17'd0, cfg_ff.nott};
         default:           csr_prdata = {17'd0, cfg_ff.maxs};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{hard: hws_pkg::HARD_RST, softt: hws_pkg::SOFT_RST,
                     nott: hws_pkg::NOT_RST, maxs: hws_pkg::MAXS_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hws_front u_front (
      .clock, .reset, .req_push, .req_full, .req_heading_x, .req_heading_y,
      .job_valid, .job_take, .job
   );

   hws_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock, .reset, .job_valid, .job_take, .job, .cfg(cfg_ff),
      .rsp_empty, .rsp_pop, .rsp_left_speed, .rsp_right_speed, .rsp_turn_mode
   );

   a_mode_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_turn_mode != 2'd3) else $error("bad turn mode");
   a_hard_sym: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_turn_mode == hws_pkg::MODE_HARD) |->
      (rsp_left_speed == -rsp_right_speed)) else $error("hard turn not symmetric");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_left_speed)))
      else $error("result dropped");
endmodule
`default_nettype wire

@@ sv/hws_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Accepts a request, does the quadrant pre-rotation and queues the job.
module hws_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_push,
   output logic                req_full,
   input  wire signed [15:0]   req_heading_x,
   input  wire signed [15:0]   req_heading_y,
   output logic                job_valid,
   input  wire                 job_take,
   output hws_pkg::job_type    job
);
   localparam int QDEPTH = hws_pkg::QDEPTH;
   localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   hws_pkg::job_type mem_ff [QDEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0] cnt_ff, cnt_in;
   hws_pkg::job_type nj;
   logic signed [25:0] xs, ys;
   logic push_ok, pop_ok;

   always_comb begin
      xs = 26'(req_heading_x) <<< 8;
      ys = 26'(req_heading_y) <<< 8;
      nj.zero = (req_heading_x == 16'sd0) && (req_heading_y == 16'sd0);
      nj.x = xs;
      nj.y = ys;
      nj.z = 34'sd0;
      if (xs < 0) begin
         if (ys >= 0) begin
            nj.x = ys; nj.y = -xs; nj.z = 34'sd1 <<< 30;
         end else begin
            nj.x = -ys; nj.y = xs; nj.z = -(34'sd1 <<< 30);
         end
      end
   end

   assign req_full = (cnt_ff == (AW+1)'(QDEPTH));
   assign push_ok = req_push && !req_full;
   assign job_valid = (cnt_ff != '0);
   assign pop_ok = job_take && job_valid;
   assign job = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff; rp_in = rp_ff; cnt_in = cnt_ff;
      if (push_ok) wp_in = (wp_ff == AW'(QDEPTH-1)) ? '0 : wp_ff + 1'b1;
      if (pop_ok) rp_in = (rp_ff == AW'(QDEPTH-1)) ? '0 : rp_ff + 1'b1;
      cnt_in = cnt_ff + (AW+1)'(push_ok) - (AW+1)'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) mem_ff[wp_ff] <= nj;
   end
endmodule
`default_nettype wire

@@ sv/hws_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// CORDIC iterations, gain, mode update, then a restoring divide for soft turn.
module hws_back #(
   parameter int CORDIC_STEPS = hws_pkg::CORDIC_STEPS_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 job_valid,
   output logic                job_take,
   input  hws_pkg::job_type    job,
   input  hws_pkg::cfg_type    cfg,
   output logic                rsp_empty,
   input  wire                 rsp_pop,
   output logic signed [16:0]  rsp_left_speed,
   output logic signed [16:0]  rsp_right_speed,
   output logic [1:0]          rsp_turn_mode
);
   localparam int NSTEP = (CORDIC_STEPS < hws_pkg::ATAN_ENTRIES) ?
                          CORDIC_STEPS : hws_pkg::ATAN_ENTRIES;
   hws_pkg::back_state_type st_ff, st_in;
   logic [4:0] i_ff, i_in;
   logic signed [25:0] x_ff, x_in, y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic zero_ff, zero_in;
   logic [42:0] prod_ff, prod_in;
   logic signed [15:0] a_ff, a_in;
   logic [15:0] m_ff, m_in;
   logic [1:0] mode_ff, mode_in;
   logic [1:0] tm_ff, tm_in;
   logic [16:0] base_ff, base_in;
   logic [31:0] rem_ff, rem_in, num_ff, num_in;
   logic [15:0] q_ff, q_in;
   logic [5:0] dc_ff, dc_in;
   logic signed [16:0] l_ff, l_in, r_ff, r_in;
   logic full_ff, full_in;
   logic signed [25:0] dx, dy;
   logic signed [33:0] zr;
   logic [26:0] lenw;
   logic [16:0] hardw;
   logic [32:0] trial;
   logic signed [17:0] s1, s2;

   always_comb begin
      st_in = st_ff; i_in = i_ff; x_in = x_ff; y_in = y_ff; z_in = z_ff;
      zero_in = zero_ff; prod_in = prod_ff; a_in = a_ff; m_in = m_ff;
      mode_in = mode_ff; base_in = base_ff; rem_in = rem_ff; num_in = num_ff;
      q_in = q_ff; dc_in = dc_ff; l_in = l_ff; r_in = r_ff; full_in = full_ff;
      tm_in = tm_ff;
      job_take = 1'b0;
      dx = y_ff >>> i_ff;
      dy = x_ff >>> i_ff;
      zr = (z_ff + 34'sd32768) >>> 16;
      lenw = 27'((prod_ff + 43'd8388608) >> 24);
      hardw = {2'b0, cfg.hard};
      trial = {rem_ff, num_ff[31]} - {15'd0, hardw, 1'b0};
      s1 = '0; s2 = '0;
      if (full_ff && rsp_pop) full_in = 1'b0;
      case (st_ff)
         hws_pkg::S_IDLE: if (job_valid) begin
            job_take = 1'b1;
            x_in = job.x; y_in = job.y; z_in = job.z; zero_in = job.zero;
            i_in = '0;
            st_in = (NSTEP == 0) ? hws_pkg::S_GAIN : hws_pkg::S_ITER;
         end
         hws_pkg::S_ITER: begin
            if (y_ff >= 0) begin
               x_in = x_ff + dx; y_in = y_ff - dy;
               z_in = z_ff + $signed({2'b0, hws_pkg::atan_lookup(i_ff)});
            end else begin
               x_in = x_ff - dx; y_in = y_ff + dy;
               z_in = z_ff - $signed({2'b0, hws_pkg::atan_lookup(i_ff)});
            end
            i_in = i_ff + 1'b1;
            if (i_ff == 5'(NSTEP-1)) st_in = hws_pkg::S_GAIN;
         end
         hws_pkg::S_GAIN: begin
            // x is nonnegative here
            prod_in = 43'(x_ff[25:0]) * 43'(hws_pkg::INV_GAIN_Q16);
            a_in = zero_ff ? 16'sd0 : zr[15:0];
            st_in = hws_pkg::S_MODE;
         end
         hws_pkg::S_MODE: begin
            base_in = zero_ff ? 17'd0 :
                      ((lenw < {12'd0, cfg.maxs}) ? lenw[16:0] : {2'b0, cfg.maxs});
            m_in = a_ff[15] ? 16'(-a_ff) : a_ff;
            if (m_in <= {1'b0, cfg.nott}) mode_in = hws_pkg::MODE_NO;
            else if (m_in > {1'b0, cfg.hard}) mode_in = hws_pkg::MODE_HARD;
            else if (mode_ff == hws_pkg::MODE_NO && m_in > {1'b0, cfg.softt})
               mode_in = hws_pkg::MODE_SOFT;
            // numerator 2*B*(h-m)+h, later divided by 2h; m <= h in soft turn
            num_in = {14'd0, base_in, 1'b0} * {15'd0, hardw - {1'b0, m_in}} +
                     {15'd0, hardw};
            rem_in = '0; q_in = '0; dc_in = '0;
            st_in = (mode_in == hws_pkg::MODE_SOFT && cfg.hard != 15'd0) ?
                    hws_pkg::S_DIV : hws_pkg::S_OUT;
         end
         hws_pkg::S_DIV: begin
            // restoring divide of num by 2h, one bit per cycle
            if (!trial[32]) rem_in = trial[31:0];
            else rem_in = {rem_ff[30:0], num_ff[31]};
            num_in = {num_ff[30:0], 1'b0};
            q_in = {q_ff[14:0], !trial[32]};
            dc_in = dc_ff + 1'b1;
            if (dc_ff == 6'd31) st_in = hws_pkg::S_OUT;
         end
         hws_pkg::S_OUT: if (!full_ff || rsp_pop) begin
            case (mode_ff)
               hws_pkg::MODE_SOFT: begin
                  s1 = (cfg.hard != 15'd0) ? $signed({2'b0, q_ff}) : 18'sd0;
                  s2 = $signed({base_ff, 1'b0}) - s1;
               end
               hws_pkg::MODE_HARD: begin
                  s1 = -$signed({3'b0, cfg.maxs}); s2 = $signed({3'b0, cfg.maxs});
               end
               default: begin
                  s1 = $signed({1'b0, base_ff}); s2 = s1;
               end
            endcase
            if (!a_ff[15] && a_ff != 16'sd0) begin
               l_in = s1[16:0]; r_in = s2[16:0];
            end else begin
               l_in = s2[16:0]; r_in = s1[16:0];
            end
            tm_in = mode_ff;
            full_in = 1'b1;
            st_in = hws_pkg::S_IDLE;
         end
         default: st_in = hws_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= hws_pkg::S_IDLE; mode_ff <= hws_pkg::MODE_NO; full_ff <= 1'b0;
         tm_ff <= hws_pkg::MODE_NO;
      end else begin
         st_ff <= st_in; mode_ff <= mode_in; full_ff <= full_in;
         tm_ff <= tm_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in; x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; zero_ff <= zero_in;
      prod_ff <= prod_in; a_ff <= a_in; m_ff <= m_in; base_ff <= base_in;
      rem_ff <= rem_in; num_ff <= num_in; q_ff <= q_in; dc_ff <= dc_in;
      l_ff <= l_in; r_ff <= r_in;
   end

   assign rsp_empty = !full_ff;
   assign rsp_left_speed = l_ff;
   assign rsp_right_speed = r_ff;
   assign rsp_turn_mode = tm_ff;
endmodule
`default_nettype wire
